@@ rtl/core/wsfr_pkg.sv @@
// Types and constants shared by the WebSocket frame receiver modules.
package wsfr_pkg;

  // Parser phase within the frame stream
  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_EXT16 = 3'd2,
    PH_EXT64 = 3'd3,
    PH_MASK  = 3'd4,
    PH_DATA  = 3'd5,
    PH_HALT  = 3'd6
  } phase_e;

  // Kind of fragmented message currently open
  typedef enum logic [1:0] {
    FRAG_NONE   = 2'd0,
    FRAG_TEXT   = 2'd1,
    FRAG_BINARY = 2'd2
  } frag_e;

  // Result event codes
  localparam logic [1:0] EV_DATA  = 2'd0;
  localparam logic [1:0] EV_EMPTY = 2'd1;
  localparam logic [1:0] EV_ERROR = 2'd2;

  // Protocol error codes
  localparam logic [1:0] ERR_BAD_OPCODE   = 2'd0;
  localparam logic [1:0] ERR_STRAY_CONT   = 2'd1;
  localparam logic [1:0] ERR_CONT_EXPECT  = 2'd2;
  localparam logic [1:0] ERR_CTRL_TOO_LONG = 2'd3;

  // Opcodes
  localparam logic [3:0] OP_CONT   = 4'd0;
  localparam logic [3:0] OP_TEXT   = 4'd1;
  localparam logic [3:0] OP_BINARY = 4'd2;
  localparam logic [3:0] OP_CLOSE  = 4'd8;

  localparam logic [6:0] LEN7_EXT16   = 7'd126;
  localparam logic [6:0] LEN7_EXT64   = 7'd127;
  localparam logic [6:0] CTRL_MAX_LEN = 7'd125;
  localparam logic [2:0] EXT16_BYTES  = 3'd2;
  localparam logic [2:0] MASK_BYTES   = 3'd4;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  data_byte;
    logic [3:0]  frame_opcode;
    logic        frame_end;
    logic        message_end;
    logic [15:0] close_code;
    logic [1:0]  error_code;
  } res_t;

endpackage

@@ rtl/core/wsfr_if.sv @@
// Valid/ready stream interfaces for received bytes and for result beats.
interface wsfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [7:0]  data_byte;
  logic [3:0]  frame_opcode;
  logic        frame_end;
  logic        message_end;
  logic [15:0] close_code;
  logic [1:0]  error_code;

  modport source (output valid, output event_res, output data_byte, output frame_opcode,
                  output frame_end, output message_end, output close_code,
                  output error_code, input ready);
  modport sink   (input valid, input event_res, input data_byte, input frame_opcode,
                  input frame_end, input message_end, input close_code,
                  input error_code, output ready);
endinterface

@@ rtl/core/websocket_frame_receiver.sv @@
// WebSocket frame receiver top level: input register, parser, result register.
//
// Receive-side deframer for the WebSocket wire format. One stream byte is
// taken per beat on rx_i and up to one result beat leaves on res_o. The block
// sustains one byte per clock while res_o is ready: a byte is held in the
// input register, the parser updates its header/length/mask state and forms
// the result in the same cycle, and the result register shows it in the
// next cycle. Header, extended-length and mask-key bytes give no result;
// each payload byte gives one unmasked data beat, an empty frame gives one
// end beat, and a protocol error gives one error beat. After an error, or
// once a close frame ends, every further byte is accepted and dropped until
// reset. Backpressure on res_o stalls the parser and, in turn, rx_i.ready.
module websocket_frame_receiver (
  input  logic       clk_i,
  input  logic       rst_ni,
  wsfr_in_if.sink    rx_i,
  wsfr_out_if.source res_o
);

  // Input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q, in_byte_d;

  logic           space;     // result register can take a beat
  logic           step;      // parser consumes the held byte
  logic           res_valid;
  wsfr_pkg::res_t res;

  assign step       = in_vld_q && space;
  assign rx_i.ready = !in_vld_q || space;

  always_comb begin
    in_vld_d  = in_vld_q;
    in_byte_d = in_byte_q;
    if (rx_i.ready) begin
      in_vld_d  = rx_i.valid;
      in_byte_d = rx_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
  end

  wsfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Only a consumed byte may load a result
  wsfr_res_reg u_res_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (res_valid),
    .res_i        (res),
    .space_o      (space),
    .res_o        (res_o)
  );

endmodule

@@ rtl/core/wsfr_parser.sv @@
// Frame parser: header, extended length, mask key, payload unmasking, checks.
module wsfr_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  output logic              res_valid_o,
  output wsfr_pkg::res_t    res_o
);

  wsfr_pkg::phase_e phase_q, phase_d;
  wsfr_pkg::frag_e  frag_q, frag_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        fin_q, fin_d;
  logic [3:0]  op_q, op_d;
  logic        masked_q, masked_d;
  logic [63:0] len_q, len_d;
  logic [63:0] done_q, done_d;
  logic [31:0] mask_q, mask_d;
  logic [15:0] acc_q, acc_d;

  always_comb begin
    logic        len_end;   // length fully known this beat
    logic        hdr_end;   // header incl. mask fully known this beat
    logic        ctrl;
    logic        last;
    logic [7:0]  key;
    logic [7:0]  d;
    logic [63:0] done_inc;

    phase_d     = phase_q;
    frag_d      = frag_q;
    cnt_d       = cnt_q;
    fin_d       = fin_q;
    op_d        = op_q;
    masked_d    = masked_q;
    len_d       = len_q;
    done_d      = done_q;
    mask_d      = mask_q;
    acc_d       = acc_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.frame_opcode = op_q;
    len_end     = 1'b0;
    hdr_end     = 1'b0;
    ctrl        = op_q[3];
    last        = 1'b0;
    key         = 8'h00;
    d           = 8'h00;
    done_inc    = done_q + 64'd1;

    if (step_i) begin
      case (phase_q)
        wsfr_pkg::PH_HDR0: begin
          fin_d   = byte_i[7];
          op_d    = byte_i[3:0];
          phase_d = wsfr_pkg::PH_HDR1;
        end
        wsfr_pkg::PH_HDR1: begin
          masked_d = byte_i[7];
          mask_d   = '0;
          cnt_d    = '0;
          len_d    = '0;
          if (byte_i[6:0] == wsfr_pkg::LEN7_EXT16) begin
            phase_d = wsfr_pkg::PH_EXT16;
          end else if (byte_i[6:0] == wsfr_pkg::LEN7_EXT64) begin
            phase_d = wsfr_pkg::PH_EXT64;
          end else begin
            len_d   = {57'd0, byte_i[6:0]};
            len_end = 1'b1;
          end
        end
        wsfr_pkg::PH_EXT16,
        wsfr_pkg::PH_EXT64: begin
          len_d = {len_q[55:0], byte_i};
          cnt_d = cnt_q + 3'd1;
          if ((phase_q == wsfr_pkg::PH_EXT16 && cnt_d == wsfr_pkg::EXT16_BYTES) ||
              (phase_q == wsfr_pkg::PH_EXT64 && cnt_d == 3'd0)) begin
            len_end = 1'b1;
          end
        end
        wsfr_pkg::PH_MASK: begin
          mask_d = {mask_q[23:0], byte_i};
          cnt_d  = cnt_q + 3'd1;
          if (cnt_d == wsfr_pkg::MASK_BYTES) begin
            hdr_end = 1'b1;
          end
        end
        wsfr_pkg::PH_DATA: begin
          case (done_q[1:0])
            2'd0:    key = mask_q[31:24];
            2'd1:    key = mask_q[23:16];
            2'd2:    key = mask_q[15:8];
            default: key = mask_q[7:0];
          endcase
          d = byte_i ^ key;
          if (op_q == wsfr_pkg::OP_CLOSE) begin
            if (done_q == 64'd0) begin
              acc_d = {d, 8'h00};
            end else if (done_q == 64'd1) begin
              acc_d = {acc_q[15:8], d};
            end
          end
          done_d = done_inc;
          last   = (done_inc == len_q);
          res_valid_o       = 1'b1;
          res_o.event_res   = wsfr_pkg::EV_DATA;
          res_o.data_byte   = d;
          res_o.frame_end   = last;
          res_o.message_end = last & (ctrl | fin_q);
          if (last && op_q == wsfr_pkg::OP_CLOSE && (|len_q[63:1])) begin
            res_o.close_code = acc_d;
          end
          if (last) begin
            phase_d = (op_q == wsfr_pkg::OP_CLOSE) ? wsfr_pkg::PH_HALT : wsfr_pkg::PH_HDR0;
          end
        end
        default: ;  // halted: bytes are dropped
      endcase

      // Length known: go fetch the mask key, or finish the header now
      if (len_end) begin
        if (masked_d) begin
          phase_d = wsfr_pkg::PH_MASK;
          cnt_d   = '0;
        end else begin
          hdr_end = 1'b1;
        end
      end

      // Header checks, in priority order
      if (hdr_end) begin
        res_o.error_code = wsfr_pkg::ERR_BAD_OPCODE;
        if (!(op_q inside {[4'd0:4'd2], [4'd8:4'd10]})) begin
          res_valid_o = 1'b1;
          res_o.event_res  = wsfr_pkg::EV_ERROR;
          res_o.error_code = wsfr_pkg::ERR_BAD_OPCODE;
          phase_d = wsfr_pkg::PH_HALT;
        end else if (op_q == wsfr_pkg::OP_CONT && frag_q == wsfr_pkg::FRAG_NONE) begin
          res_valid_o = 1'b1;
          res_o.event_res  = wsfr_pkg::EV_ERROR;
          res_o.error_code = wsfr_pkg::ERR_STRAY_CONT;
          phase_d = wsfr_pkg::PH_HALT;
        end else if ((op_q == wsfr_pkg::OP_TEXT || op_q == wsfr_pkg::OP_BINARY) &&
                     frag_q != wsfr_pkg::FRAG_NONE) begin
          res_valid_o = 1'b1;
          res_o.event_res  = wsfr_pkg::EV_ERROR;
          res_o.error_code = wsfr_pkg::ERR_CONT_EXPECT;
          phase_d = wsfr_pkg::PH_HALT;
        end else if (ctrl && ((|len_d[63:7]) || len_d[6:0] > wsfr_pkg::CTRL_MAX_LEN)) begin
          res_valid_o = 1'b1;
          res_o.event_res  = wsfr_pkg::EV_ERROR;
          res_o.error_code = wsfr_pkg::ERR_CTRL_TOO_LONG;
          phase_d = wsfr_pkg::PH_HALT;
        end else begin
          res_o.error_code = wsfr_pkg::ERR_BAD_OPCODE;
          // Fragment bookkeeping
          if (op_q == wsfr_pkg::OP_CONT) begin
            if (fin_q) frag_d = wsfr_pkg::FRAG_NONE;
          end else if (!ctrl) begin
            if (fin_q) begin
              frag_d = wsfr_pkg::FRAG_NONE;
            end else if (op_q == wsfr_pkg::OP_TEXT) begin
              frag_d = wsfr_pkg::FRAG_TEXT;
            end else begin
              frag_d = wsfr_pkg::FRAG_BINARY;
            end
          end
          done_d = '0;
          acc_d  = '0;
          if (len_d == 64'd0) begin
            res_valid_o       = 1'b1;
            res_o.event_res   = wsfr_pkg::EV_EMPTY;
            res_o.frame_end   = 1'b1;
            res_o.message_end = ctrl | fin_q;
            phase_d = (op_q == wsfr_pkg::OP_CLOSE) ? wsfr_pkg::PH_HALT : wsfr_pkg::PH_HDR0;
          end else begin
            phase_d = wsfr_pkg::PH_DATA;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wsfr_pkg::PH_HDR0;
      frag_q   <= wsfr_pkg::FRAG_NONE;
      cnt_q    <= '0;
      fin_q    <= 1'b0;
      op_q     <= '0;
      masked_q <= 1'b0;
      len_q    <= '0;
      done_q   <= '0;
      mask_q   <= '0;
      acc_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      frag_q   <= frag_d;
      cnt_q    <= cnt_d;
      fin_q    <= fin_d;
      op_q     <= op_d;
      masked_q <= masked_d;
      len_q    <= len_d;
      done_q   <= done_d;
      mask_q   <= mask_d;
      acc_q    <= acc_d;
    end
  end

endmodule

@@ rtl/core/wsfr_res_reg.sv @@
// Result register driving the output stream.
module wsfr_res_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_valid_i,
  input  wsfr_pkg::res_t res_i,
  output logic           space_o,
  wsfr_out_if.source     res_o
);

  logic           vld_q, vld_d;
  wsfr_pkg::res_t res_q, res_d;

  assign space_o = !vld_q || res_o.ready;

  always_comb begin
    vld_d = vld_q;
    res_d = res_q;
    if (space_o) begin
      vld_d = load_valid_i;
      res_d = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o.valid        = vld_q;
  assign res_o.event_res    = res_q.event_res;
  assign res_o.data_byte    = res_q.data_byte;
  assign res_o.frame_opcode = res_q.frame_opcode;
  assign res_o.frame_end    = res_q.frame_end;
  assign res_o.message_end  = res_q.message_end;
  assign res_o.close_code   = res_q.close_code;
  assign res_o.error_code   = res_q.error_code;

endmodule
